// ----- design/rgb_color_balance_keep_lightness_unit_defines.svh -----
// assertion helpers used by the checker module
`ifndef RGB_COLOR_BALANCE_KEEP_LIGHTNESS_UNIT_DEFINES_SVH
`define RGB_COLOR_BALANCE_KEEP_LIGHTNESS_UNIT_DEFINES_SVH

// property that is only checked out of reset
`define CBKL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property that is checked at every edge, reset included
`define CBKL_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/cbkl_pkg.sv -----
package cbkl_pkg;

    // field and register widths
    localparam int unsigned FIELD_W = 13;
    localparam int unsigned ADJ_W   = 48;
    localparam int unsigned PART_W  = 16;

    // weights are Q16
    localparam int unsigned W_ONE    = 65536;
    localparam int unsigned RAMP_B4  = 87294;
    localparam int unsigned SCALE_07 = 45875;

    // hue units per turn
    localparam int unsigned HUE_TURN  = 196608;
    localparam int unsigned HUE_SIXTH = 32768;
    localparam int unsigned HUE_THIRD = 65536;

    // quotient bits of the saturation and hue dividers
    localparam int unsigned QUO_W = 18;

    // configuration register indexes
    localparam logic [1:0] CFG_RED   = 2'd0;
    localparam logic [1:0] CFG_GREEN = 2'd1;
    localparam logic [1:0] CFG_BLUE  = 2'd2;

    typedef struct packed {
        logic [FIELD_W-1:0] in_red;
        logic [FIELD_W-1:0] in_green;
        logic [FIELD_W-1:0] in_blue;
    } in_pix_t;

    typedef struct packed {
        logic [FIELD_W-1:0] out_red;
        logic [FIELD_W-1:0] out_green;
        logic [FIELD_W-1:0] out_blue;
    } out_pix_t;

    // clamp a ramp value to the weight range 0..1.0
    function automatic logic [16:0] clamp_w(input logic signed [20:0] x);
        logic [16:0] r;
        if (x < 0) begin
            r = '0;
        end else if (x > 21'sd65536) begin
            r = 17'(W_ONE);
        end else begin
            r = x[16:0];
        end
        return r;
    endfunction

endpackage

// ----- design/rgb_color_balance_keep_lightness_unit.sv -----
// channel  | direction | payload             | handshake
// s_       | in        | in_pix_t  (r, g, b) | s_valid / s_ready
// m_       | out       | out_pix_t (r, g, b) | m_valid / m_ready
// cfg_     | in        | 48-bit adjust word  | cfg_we, no wait
//
// one word per cycle while the pipe runs; from input to output: input clamp, four
// balance stages, two stages of hue setup, 18 stages of the bit-per-stage
// saturation and hue dividers, three rebuild stages and the output register.
// aresetn is synchronous; it empties the pipe and zeroes the adjust registers.
// the pipe halts only while the output skid word is held, which s_ready shows.
module rgb_color_balance_keep_lightness_unit #(
    parameter int unsigned CHANNEL_FRAC_BITS = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  cbkl_pkg::in_pix_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output cbkl_pkg::out_pix_t         m_data,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [cbkl_pkg::ADJ_W-1:0] cfg_data
);

    localparam int unsigned F       = CHANNEL_FRAC_BITS;
    localparam int unsigned CW      = F + 1;
    localparam int unsigned LW      = F + 2;
    localparam int unsigned TNW     = F + 3;
    localparam int unsigned NW      = F + 18;
    localparam int unsigned MW      = F + 19;
    localparam int unsigned VW      = F + 35;
    localparam int unsigned OW      = F + 3;
    localparam int unsigned QW      = cbkl_pkg::QUO_W;
    localparam int unsigned BAL_LAT = 4;
    localparam int unsigned CH_ONE  = 1 << F;

    logic en;

    // adjust registers
    logic [cbkl_pkg::ADJ_W-1:0] adj_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adj_reg[0] <= '0;
            adj_reg[1] <= '0;
            adj_reg[2] <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                cbkl_pkg::CFG_RED:   adj_reg[0] <= cfg_data;
                cbkl_pkg::CFG_GREEN: adj_reg[1] <= cfg_data;
                cbkl_pkg::CFG_BLUE:  adj_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // input clamp and lightness sum
    function automatic logic [CW-1:0] clamp_in(input logic [cbkl_pkg::FIELD_W-1:0] x);
        return (17'(x) > 17'(CH_ONE)) ? CW'(CH_ONE) : CW'(x);
    endfunction

    logic [CW-1:0] ci [3];
    logic [CW-1:0] hi1, lo1;
    logic [CW-1:0] c_reg [3];
    logic [LW-1:0] lsum1_reg;
    logic          v1_reg;

    assign ci[0] = clamp_in(s_data.in_red);
    assign ci[1] = clamp_in(s_data.in_green);
    assign ci[2] = clamp_in(s_data.in_blue);

    always_comb begin
        hi1 = ci[0];
        lo1 = ci[0];
        for (int k = 1; k < 3; k++) begin
            if (ci[k] > hi1) hi1 = ci[k];
            if (ci[k] < lo1) lo1 = ci[k];
        end
    end

    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg[0]  <= ci[0];
            c_reg[1]  <= ci[1];
            c_reg[2]  <= ci[2];
            lsum1_reg <= LW'(hi1) + LW'(lo1);
        end
    end

    // per-channel balance
    logic [CW-1:0] b [3];

    for (genvar k = 0; k < 3; k++) begin : g_bal
        cbkl_bal #(.CHANNEL_FRAC_BITS(F)) u_bal (
            .aclk (aclk),
            .en   (en),
            .chan (c_reg[k]),
            .adj  (adj_reg[k]),
            .bal  (b[k])
        );
    end

    // side data beside the balance stages
    logic [LW-1:0] lsum_p_reg [BAL_LAT];
    logic          vld_p_reg  [BAL_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < BAL_LAT; k++) vld_p_reg[k] <= 1'b0;
        end else if (en) begin
            vld_p_reg[0] <= v1_reg;
            for (int k = 1; k < BAL_LAT; k++) vld_p_reg[k] <= vld_p_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lsum_p_reg[0] <= lsum1_reg;
            for (int k = 1; k < BAL_LAT; k++) lsum_p_reg[k] <= lsum_p_reg[k-1];
        end
    end

    // spread, denominator and hue sector of the balanced pixel
    logic [CW-1:0]        hi6, lo6, d6;
    logic [LW-1:0]        sum6;
    logic [CW-1:0]        den6;
    logic signed [TNW:0]  bs0, bs1, bs2, ds6, tn_s;
    logic [CW-1:0]        d6_reg, den6_reg;
    logic [TNW-1:0]       tn6_reg;
    logic                 gray6_reg, v6_reg;
    logic [LW-1:0]        lsum6_reg;

    always_comb begin
        hi6 = b[0];
        lo6 = b[0];
        for (int k = 1; k < 3; k++) begin
            if (b[k] > hi6) hi6 = b[k];
            if (b[k] < lo6) lo6 = b[k];
        end
    end

    assign d6   = hi6 - lo6;
    assign sum6 = LW'(hi6) + LW'(lo6);
    assign den6 = (sum6 <= LW'(CH_ONE)) ? CW'(sum6) : CW'(LW'(2 * CH_ONE) - sum6);
    assign bs0  = $signed((TNW + 1)'(b[0]));
    assign bs1  = $signed((TNW + 1)'(b[1]));
    assign bs2  = $signed((TNW + 1)'(b[2]));
    assign ds6  = $signed((TNW + 1)'(d6));

    always_comb begin
        if (b[0] == hi6) begin
            tn_s = bs1 - bs2;
            if (tn_s < 0) tn_s = tn_s + (ds6 <<< 2) + (ds6 <<< 1);
        end else if (b[1] == hi6) begin
            tn_s = (ds6 <<< 1) + bs2 - bs0;
        end else begin
            tn_s = (ds6 <<< 2) + bs0 - bs1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= vld_p_reg[BAL_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d6_reg    <= d6;
            den6_reg  <= den6;
            tn6_reg   <= tn_s[TNW-1:0];
            gray6_reg <= (d6 == '0);
            lsum6_reg <= lsum_p_reg[BAL_LAT-1];
        end
    end

    // divider numerators with half-divisor rounding
    logic [NW-1:0] num_sat7_reg, num_hue7_reg;
    logic [CW-1:0] den7_reg, d7_reg;
    logic [LW-1:0] lsum7_reg;
    logic          gray7_reg, v7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_sat7_reg <= (NW'(d6_reg) << 16) + NW'(den6_reg >> 1);
            num_hue7_reg <= (NW'(tn6_reg) << 15) + NW'(d6_reg >> 1);
            den7_reg     <= den6_reg;
            d7_reg       <= d6_reg;
            lsum7_reg    <= lsum6_reg;
            gray7_reg    <= gray6_reg;
        end
    end

    // saturation and hue dividers
    logic [QW-1:0] quo_sat, quo_hue;

    cbkl_div #(.NW(NW), .DW(CW), .QW(QW)) u_div_sat (
        .aclk (aclk),
        .en   (en),
        .num  (num_sat7_reg),
        .den  (den7_reg),
        .quo  (quo_sat)
    );

    cbkl_div #(.NW(NW), .DW(CW), .QW(QW)) u_div_hue (
        .aclk (aclk),
        .en   (en),
        .num  (num_hue7_reg),
        .den  (d7_reg),
        .quo  (quo_hue)
    );

    // side data beside the dividers
    logic [LW-1:0] lsum_q_reg [QW];
    logic          gray_q_reg [QW];
    logic          vld_q_reg  [QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < QW; k++) vld_q_reg[k] <= 1'b0;
        end else if (en) begin
            vld_q_reg[0] <= v7_reg;
            for (int k = 1; k < QW; k++) vld_q_reg[k] <= vld_q_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lsum_q_reg[0] <= lsum7_reg;
            gray_q_reg[0] <= gray7_reg;
            for (int k = 1; k < QW; k++) begin
                lsum_q_reg[k] <= lsum_q_reg[k-1];
                gray_q_reg[k] <= gray_q_reg[k-1];
            end
        end
    end

    // hue wrap, three hue angles and m2
    logic [16:0]   sat_a;
    logic [17:0]   hue_a;
    logic [18:0]   h0_sum, h2_sum;
    logic [17:0]   h_a [3];
    logic [LW-1:0] lsum_a;
    logic          lo_half;
    logic [LW-1:0] mx;
    logic [17:0]   my;
    logic [MW-1:0] m2_a;

    assign lsum_a  = lsum_q_reg[QW-1];
    assign sat_a   = (quo_sat > QW'(cbkl_pkg::W_ONE)) ? 17'(cbkl_pkg::W_ONE) : quo_sat[16:0];
    assign hue_a   = (quo_hue >= QW'(cbkl_pkg::HUE_TURN)) ?
                     (quo_hue - QW'(cbkl_pkg::HUE_TURN)) : quo_hue;
    assign h0_sum  = 19'(hue_a) + 19'(cbkl_pkg::HUE_THIRD);
    assign h2_sum  = 19'(hue_a) + 19'(2 * cbkl_pkg::HUE_THIRD);
    assign h_a[0]  = (h0_sum >= 19'(cbkl_pkg::HUE_TURN)) ?
                     18'(h0_sum - 19'(cbkl_pkg::HUE_TURN)) : 18'(h0_sum);
    assign h_a[1]  = hue_a;
    assign h_a[2]  = (h2_sum >= 19'(cbkl_pkg::HUE_TURN)) ?
                     18'(h2_sum - 19'(cbkl_pkg::HUE_TURN)) : 18'(h2_sum);
    assign lo_half = (lsum_a <= LW'(CH_ONE));
    assign mx      = lo_half ? lsum_a : (LW'(2 * CH_ONE) - lsum_a);
    assign my      = lo_half ? (18'(cbkl_pkg::W_ONE) + 18'(sat_a)) : 18'(sat_a);
    assign m2_a    = (lo_half ? MW'(0) : (MW'(lsum_a) << 16)) + MW'(mx) * MW'(my);

    logic [MW-1:0] m2a_reg;
    logic [17:0]   ha_reg [3];
    logic [LW-1:0] lsuma_reg;
    logic          graya_reg, va_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= vld_q_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m2a_reg   <= m2_a;
            ha_reg[0] <= h_a[0];
            ha_reg[1] <= h_a[1];
            ha_reg[2] <= h_a[2];
            lsuma_reg <= lsum_a;
            graya_reg <= gray_q_reg[QW-1];
        end
    end

    // m1 and the m2 - m1 slope
    logic [MW-1:0] m1b_reg, m2b_reg, diffb_reg;
    logic [17:0]   hb_reg [3];
    logic [LW-1:0] lsumb_reg;
    logic          grayb_reg, vb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1b_reg   <= (MW'(lsuma_reg) << 17) - m2a_reg;
            m2b_reg   <= m2a_reg;
            diffb_reg <= (m2a_reg << 1) - (MW'(lsuma_reg) << 17);
            hb_reg[0] <= ha_reg[0];
            hb_reg[1] <= ha_reg[1];
            hb_reg[2] <= ha_reg[2];
            lsumb_reg <= lsuma_reg;
            grayb_reg <= graya_reg;
        end
    end

    // hue curve segment and slope product per channel
    logic [MW-1:0] basec [3];
    logic [15:0]   mulc  [3];
    logic [MW-1:0] basec_reg [3];
    logic [VW-1:0] prodc_reg [3];
    logic [LW-1:0] lsumc_reg;
    logic          grayc_reg, vc_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (hb_reg[k] < 18'(cbkl_pkg::HUE_SIXTH)) begin
                basec[k] = m1b_reg;
                mulc[k]  = hb_reg[k][15:0];
            end else if (hb_reg[k] < 18'(3 * cbkl_pkg::HUE_SIXTH)) begin
                basec[k] = m2b_reg;
                mulc[k]  = '0;
            end else if (hb_reg[k] < 18'(4 * cbkl_pkg::HUE_SIXTH)) begin
                basec[k] = m1b_reg;
                mulc[k]  = 16'(18'(4 * cbkl_pkg::HUE_SIXTH) - hb_reg[k]);
            end else begin
                basec[k] = m1b_reg;
                mulc[k]  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                basec_reg[k] <= basec[k];
                prodc_reg[k] <= VW'(diffb_reg) * VW'(mulc[k]);
            end
            lsumc_reg <= lsumb_reg;
            grayc_reg <= grayb_reg;
        end
    end

    // final rounding, clamp and gray bypass
    logic [VW-1:0] vsum [3];
    logic [OW-1:0] oval [3];
    logic [OW-1:0] ocl  [3];
    logic [LW-1:0] lhalf;
    cbkl_pkg::out_pix_t pix_d;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vsum[k] = (VW'(basec_reg[k]) << 15) + prodc_reg[k] + (VW'(1) << 31);
            oval[k] = vsum[k][VW-1:32];
            ocl[k]  = (oval[k] > OW'(CH_ONE)) ? OW'(CH_ONE) : oval[k];
        end
    end

    assign lhalf = (lsumc_reg + LW'(1)) >> 1;

    always_comb begin
        if (grayc_reg) begin
            pix_d.out_red   = cbkl_pkg::FIELD_W'(lhalf);
            pix_d.out_green = cbkl_pkg::FIELD_W'(lhalf);
            pix_d.out_blue  = cbkl_pkg::FIELD_W'(lhalf);
        end else begin
            pix_d.out_red   = cbkl_pkg::FIELD_W'(ocl[0]);
            pix_d.out_green = cbkl_pkg::FIELD_W'(ocl[1]);
            pix_d.out_blue  = cbkl_pkg::FIELD_W'(ocl[2]);
        end
    end

    // output register with skid word; its room drives the pipe enable
    cbkl_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vc_reg),
        .in_ready  (en),
        .in_data   (pix_d),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// ----- design/cbkl_bal.sv -----
module cbkl_bal #(
    parameter int unsigned CHANNEL_FRAC_BITS = 12,
    localparam int unsigned CW = CHANNEL_FRAC_BITS + 1
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [CW-1:0]              chan,
    input  logic [cbkl_pkg::ADJ_W-1:0] adj,
    output logic [CW-1:0]              bal
);

    localparam int SH     = 29 - CHANNEL_FRAC_BITS;
    localparam int V4SH   = 18 - CHANNEL_FRAC_BITS;
    localparam int CH_ONE = 1 << CHANNEL_FRAC_BITS;
    localparam int CS_OFF = cbkl_pkg::W_ONE / 2 + cbkl_pkg::RAMP_B4;
    localparam int C1_OFF = cbkl_pkg::RAMP_B4 - cbkl_pkg::W_ONE / 2;
    localparam int C2_OFF = 4 * cbkl_pkg::W_ONE - cbkl_pkg::RAMP_B4 + cbkl_pkg::W_ONE / 2;
    localparam int CH_OFF = 4 * cbkl_pkg::W_ONE - cbkl_pkg::RAMP_B4 - cbkl_pkg::W_ONE / 2;

    logic [19:0]        v4u;
    logic signed [20:0] v4s;
    logic [16:0]        cs, c1, c2, chi;
    logic [33:0]        ps_full, pm_full, ph_full, wm_full;

    logic [16:0] ws2_reg, cm2_reg, wh2_reg;
    logic [CW-1:0] v2_reg;
    logic [16:0] ws3_reg, wm3_reg, wh3_reg;
    logic [CW-1:0] v3_reg;
    logic signed [33:0] p0, p1, p2;
    logic signed [33:0] p0_reg, p1_reg, p2_reg;
    logic [CW-1:0] v4_reg;
    logic signed [35:0] base, tsum, trnd;
    logic [35:0] rsh;
    logic [CW-1:0] bal_next, bal_reg;

    // ramps of the channel value
    assign v4u = 20'(chan) << V4SH;
    assign v4s = $signed({1'b0, v4u});
    assign cs  = cbkl_pkg::clamp_w($signed(21'(CS_OFF)) - v4s);
    assign c1  = cbkl_pkg::clamp_w(v4s - $signed(21'(C1_OFF)));
    assign c2  = cbkl_pkg::clamp_w($signed(21'(C2_OFF)) - v4s);
    assign chi = cbkl_pkg::clamp_w(v4s - $signed(21'(CH_OFF)));

    // first products, rounded to Q16
    assign ps_full = 34'(cs) * 34'(cbkl_pkg::SCALE_07) + 34'(32768);
    assign pm_full = 34'(c1) * 34'(c2) + 34'(32768);
    assign ph_full = 34'(chi) * 34'(cbkl_pkg::SCALE_07) + 34'(32768);

    always_ff @(posedge aclk) begin
        if (en) begin
            ws2_reg <= ps_full[32:16];
            cm2_reg <= pm_full[32:16];
            wh2_reg <= ph_full[32:16];
            v2_reg  <= chan;
        end
    end

    // midtone weight gets its scale
    assign wm_full = 34'(cm2_reg) * 34'(cbkl_pkg::SCALE_07) + 34'(32768);

    always_ff @(posedge aclk) begin
        if (en) begin
            ws3_reg <= ws2_reg;
            wm3_reg <= wm_full[32:16];
            wh3_reg <= wh2_reg;
            v3_reg  <= v2_reg;
        end
    end

    // offset times weight
    assign p0 = $signed(adj[15:0])  * $signed({1'b0, ws3_reg});
    assign p1 = $signed(adj[31:16]) * $signed({1'b0, wm3_reg});
    assign p2 = $signed(adj[47:32]) * $signed({1'b0, wh3_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg <= p0;
            p1_reg <= p1;
            p2_reg <= p2;
            v4_reg <= v3_reg;
        end
    end

    // exact sum, round to channel format and clamp
    assign base = $signed(36'(v4_reg) << SH);
    assign tsum = base + p0_reg + p1_reg + p2_reg;
    assign trnd = tsum + $signed(36'(1) << (SH - 1));
    assign rsh  = 36'(trnd) >> SH;

    always_comb begin
        if (tsum < 0) begin
            bal_next = '0;
        end else if (rsh > 36'(CH_ONE)) begin
            bal_next = CW'(CH_ONE);
        end else begin
            bal_next = rsh[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bal_reg <= bal_next;
        end
    end

    assign bal = bal_reg;

endmodule

// ----- design/cbkl_div.sv -----
module cbkl_div #(
    parameter int unsigned NW = 30,
    parameter int unsigned DW = 13,
    parameter int unsigned QW = 18
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int unsigned RW = (NW > DW + QW) ? NW : DW + QW;

    logic [RW-1:0] rem_reg [QW];
    logic [DW-1:0] dvs_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    // one quotient bit per stage, restoring
    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [RW-1:0] rem_in;
        logic [DW-1:0] dvs_in;
        logic [QW-1:0] quo_in;
        logic [RW-1:0] shd;
        logic          fit;

        if (g == 0) begin : g_first
            assign rem_in = RW'(num);
            assign dvs_in = den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[g-1];
            assign dvs_in = dvs_reg[g-1];
            assign quo_in = quo_reg[g-1];
        end

        assign shd = RW'(dvs_in) << (QW - 1 - g);
        assign fit = (rem_in >= shd);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= fit ? (rem_in - shd) : rem_in;
                dvs_reg[g] <= dvs_in;
                quo_reg[g] <= quo_in | (fit ? (QW'(1) << (QW - 1 - g)) : '0);
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

// ----- design/cbkl_obuf.sv -----
module cbkl_obuf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  cbkl_pkg::out_pix_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cbkl_pkg::out_pix_t out_data
);

    logic               out_valid_reg, skid_valid_reg;
    cbkl_pkg::out_pix_t out_data_reg, skid_data_reg;
    logic               out_load, skid_load, skid_pop;

    // word goes to skid only when output holds a stalled word
    assign in_ready  = !skid_valid_reg;
    assign skid_load = !skid_valid_reg && in_valid && out_valid_reg && !out_ready;
    assign out_load  = !skid_valid_reg && (!out_valid_reg || out_ready);
    assign skid_pop  = skid_valid_reg && out_ready;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_load) begin
                skid_valid_reg <= 1'b1;
            end else if (skid_pop) begin
                skid_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= in_valid;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (skid_load) begin
            skid_data_reg <= in_data;
        end
        if (skid_pop) begin
            out_data_reg <= skid_data_reg;
        end else if (out_load) begin
            out_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- design/cbkl_chk.sv -----
`include "rgb_color_balance_keep_lightness_unit_defines.svh"

module cbkl_chk #(
    parameter int unsigned CHANNEL_FRAC_BITS = 12
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input cbkl_pkg::out_pix_t m_data
);

    localparam int unsigned OUT_MAX = (CHANNEL_FRAC_BITS < 13) ? (1 << CHANNEL_FRAC_BITS) : 8191;
    localparam logic [cbkl_pkg::FIELD_W-1:0] LIM = cbkl_pkg::FIELD_W'(OUT_MAX);

    // reset empties the output and frees the input
    `CBKL_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !m_valid && s_ready, "not empty after reset")

    // a stalled word holds
    `CBKL_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled word changed")

    // input is held back only while a word waits at the output
    `CBKL_ASSERT(a_full_has_word, aclk, aresetn, !s_ready |-> m_valid, "input stalled with empty output")

    // input ready drops only after an output stall
    `CBKL_ASSERT(a_ready_drop, aclk, aresetn, !s_ready && $past(s_ready) |-> $past(m_valid && !m_ready), "ready dropped without stall")

    // channels stay within 0..1.0
    `CBKL_ASSERT(a_range, aclk, aresetn, m_valid |-> m_data.out_red <= LIM && m_data.out_green <= LIM && m_data.out_blue <= LIM, "channel above 1.0")

endmodule

bind rgb_color_balance_keep_lightness_unit cbkl_chk #(
    .CHANNEL_FRAC_BITS(CHANNEL_FRAC_BITS)
) u_cbkl_chk (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int LATENCY   = 30;
    localparam int MAX_CYC   = 400000;
    localparam int HOLD_CYC  = 120;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    cbkl_pkg::in_pix_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    cbkl_pkg::out_pix_t m_data;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = cbkl_pkg::CFG_RED;
    logic [cbkl_pkg::ADJ_W-1:0] cfg_data = '0;

    // predictor copy of the adjust registers
    logic [cbkl_pkg::ADJ_W-1:0] adj_regs [3];

    cbkl_pkg::in_pix_t  pix_pending [$];
    cbkl_pkg::out_pix_t pix_expected [$];
    int errors = 0;
    int cycles = 0;
    bit stall_on = 1'b1;      // random idling enabled
    bit hold_req = 1'b0;      // long receiver hold request
    int hold_cnt = 0;         // cycles spent in the hold
    bit sender_pause = 1'b0;
    bit in_taken = 1'b0;      // input word accepted at the last rising edge

    rgb_color_balance_keep_lightness_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic longint clamp_q16(longint x);
        return (x < 0) ? 0 : ((x > 65536) ? 65536 : x);
    endfunction

    // adjust one channel with its three ramp-weighted offsets
    function automatic longint balance_chan(longint v, logic [cbkl_pkg::ADJ_W-1:0] reg_val);
        longint v4, cs, c1, c2, chh, ws, cm, wm, wh, t, r;
        logic signed [15:0] sh_off, md_off, hl_off;
        v4 = v << 6;
        cs = clamp_q16(32768 + 87294 - v4);
        c1 = clamp_q16(v4 - (87294 - 32768));
        c2 = clamp_q16((4 * 65536 - 87294 + 32768) - v4);
        chh = clamp_q16(v4 - (4 * 65536 - 87294 - 32768));
        ws = (cs * 45875 + 32768) >>> 16;
        cm = (c1 * c2 + 32768) >>> 16;
        wm = (cm * 45875 + 32768) >>> 16;
        wh = (chh * 45875 + 32768) >>> 16;
        sh_off = reg_val[15:0];
        md_off = reg_val[31:16];
        hl_off = reg_val[47:32];
        t = v << 17;
        t += longint'(sh_off) * ws + longint'(md_off) * wm + longint'(hl_off) * wh;
        if (t < 0) return 0;
        r = (t + (longint'(1) << 16)) >>> 17;
        return (r > 4096) ? 4096 : r;
    endfunction

    function automatic longint hue_level(longint m1, longint m2, longint hue);
        longint v;
        if (hue < 32768) v = m1 * 32768 + (m2 - m1) * hue;
        else if (hue < 3 * 32768) v = m2 * 32768;
        else if (hue < 4 * 32768) v = m1 * 32768 + (m2 - m1) * (4 * 32768 - hue);
        else v = m1 * 32768;
        v = (v + (longint'(1) << 31)) >>> 32;
        if (v > 4096) v = 4096;
        if (v < 0) v = 0;
        return v;
    endfunction

    // expected balanced pixel with the input lightness kept
    function automatic cbkl_pkg::out_pix_t balance_pixel(cbkl_pkg::in_pix_t p);
        longint c [3];
        longint b [3];
        longint o [3];
        longint hi, lo, d, lsum, sum, den, sat, tn, hue, m1, m2;
        cbkl_pkg::out_pix_t res;
        c[0] = p.in_red; c[1] = p.in_green; c[2] = p.in_blue;
        for (int i = 0; i < 3; i++) if (c[i] > 4096) c[i] = 4096;
        hi = c[0]; lo = c[0];
        for (int i = 1; i < 3; i++) begin
            if (c[i] > hi) hi = c[i];
            if (c[i] < lo) lo = c[i];
        end
        lsum = hi + lo;
        for (int i = 0; i < 3; i++) b[i] = balance_chan(c[i], adj_regs[i]);
        hi = b[0]; lo = b[0];
        for (int i = 1; i < 3; i++) begin
            if (b[i] > hi) hi = b[i];
            if (b[i] < lo) lo = b[i];
        end
        d = hi - lo;
        sum = hi + lo;
        if (d == 0) begin
            o[0] = (lsum + 1) >>> 1; o[1] = o[0]; o[2] = o[0];
        end else begin
            den = (sum <= 4096) ? sum : (8192 - sum);
            sat = ((d << 16) + den / 2) / den;
            if (sat > 65536) sat = 65536;
            if (b[0] == hi) begin
                tn = b[1] - b[2];
                if (tn < 0) tn += 6 * d;
            end else if (b[1] == hi) begin
                tn = 2 * d + (b[2] - b[0]);
            end else begin
                tn = 4 * d + (b[0] - b[1]);
            end
            hue = ((tn * 32768 + d / 2) / d) % 196608;
            if (lsum <= 4096) m2 = lsum * (65536 + sat);
            else m2 = lsum * 65536 + sat * (8192 - lsum);
            m1 = 2 * lsum * 65536 - m2;
            o[0] = hue_level(m1, m2, (hue + 65536) % 196608);
            o[1] = hue_level(m1, m2, hue);
            o[2] = hue_level(m1, m2, (hue + 196608 - 65536) % 196608);
        end
        res.out_red = o[0][12:0];
        res.out_green = o[1][12:0];
        res.out_blue = o[2][12:0];
        return res;
    endfunction

    function automatic cbkl_pkg::in_pix_t rand_pixel();
        cbkl_pkg::in_pix_t p;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // out-of-range values saturate to 1.0
            p = {13'($urandom), 13'($urandom), 13'($urandom)};
        end else if (kind == 1) begin
            // gray pixel
            p.in_red = 13'($urandom_range(0, 4096));
            p.in_green = p.in_red;
            p.in_blue = p.in_red;
        end else if (kind == 2) begin
            // red and green tied
            p.in_red = 13'($urandom_range(0, 4096));
            p.in_green = p.in_red;
            p.in_blue = 13'($urandom_range(0, 4096));
        end else begin
            p.in_red = 13'($urandom_range(0, 4096));
            p.in_green = 13'($urandom_range(0, 4096));
            p.in_blue = 13'($urandom_range(0, 4096));
        end
        return p;
    endfunction

    function automatic logic [cbkl_pkg::ADJ_W-1:0] rand_adjust();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    // driver: words leave the pending queue at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (pix_pending.size() > 0 && !sender_pause &&
                    !(stall_on && $urandom_range(0, 99) < 25)) begin
                    s_valid <= 1'b1;
                    s_data <= pix_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // hold length counted in cycles
    always @(posedge aclk) begin
        if (!hold_req) hold_cnt <= 0;
        else if (hold_cnt < HOLD_CYC) hold_cnt <= hold_cnt + 1;
    end

    // receiver ready with random idling and a forced hold
    always @(negedge aclk) begin
        if (aresetn)
            m_ready <= !(hold_req && hold_cnt < HOLD_CYC) &&
                       !(stall_on && $urandom_range(0, 99) < 25);
    end

    // monitor: predict accepted input words, compare each result word
    always @(posedge aclk) begin
        cbkl_pkg::out_pix_t exp_pix;
        cycles <= cycles + 1;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            pix_expected.push_back(balance_pixel(s_data));
        end
        if (aresetn && m_valid && m_ready) begin
            if (pix_expected.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10) $display("unexpected word %h", m_data);
            end else begin
                exp_pix = pix_expected.pop_front();
                if (exp_pix !== m_data) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("mismatch: expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                                 exp_pix.out_red, exp_pix.out_green, exp_pix.out_blue,
                                 m_data.out_red, m_data.out_green, m_data.out_blue);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (cycles >= MAX_CYC) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pix_pending.size() > 0 || s_valid || pix_expected.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic write_adjust(logic [1:0] idx, logic [cbkl_pkg::ADJ_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        adj_regs[idx] = val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(logic [cbkl_pkg::ADJ_W-1:0] r, logic [cbkl_pkg::ADJ_W-1:0] g,
                           logic [cbkl_pkg::ADJ_W-1:0] b);
        write_adjust(cbkl_pkg::CFG_RED, r);
        write_adjust(cbkl_pkg::CFG_GREEN, g);
        write_adjust(cbkl_pkg::CFG_BLUE, b);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) pix_pending.push_back(rand_pixel());
    endtask

    initial begin
        for (int i = 0; i < 3; i++) adj_regs[i] = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed pixels at reset settings
        pix_pending.push_back({13'd0, 13'd0, 13'd0});
        pix_pending.push_back({13'd4096, 13'd4096, 13'd4096});
        pix_pending.push_back({13'h1FFF, 13'h1FFF, 13'h1FFF});
        pix_pending.push_back({13'd4096, 13'd0, 13'd0});
        pix_pending.push_back({13'd0, 13'd4096, 13'd0});
        pix_pending.push_back({13'd0, 13'd0, 13'd4096});
        pix_pending.push_back({13'd4096, 13'd4096, 13'd0});
        pix_pending.push_back({13'd0, 13'd4096, 13'd4096});
        pix_pending.push_back({13'd2048, 13'd1024, 13'd3000});
        pix_pending.push_back({13'h1555, 13'h0AAA, 13'd100});
        wait_drained();

        // extreme offsets: positive max for red, negative max for green, mixed for blue; gray and tied inputs
        set_all({3{16'h7FFF}}, {3{16'h8000}}, {16'h7FFF, 16'h8000, 16'h0001});
        pix_pending.push_back({13'd2048, 13'd2048, 13'd2048});
        pix_pending.push_back({13'd3000, 13'd3000, 13'd500});
        pix_pending.push_back({13'd4096, 13'd1000, 13'd4096});
        pix_pending.push_back({13'd1, 13'd4095, 13'd2000});
        pix_pending.push_back({13'h1FFF, 13'd0, 13'd1234});
        pix_pending.push_back({13'd0, 13'd0, 13'd0});
        pix_pending.push_back({13'd4096, 13'd4096, 13'd4096});
        wait_drained();

        // long receiver hold while the sender keeps offering
        set_all(rand_adjust(), rand_adjust(), rand_adjust());
        stall_on = 1'b0;
        hold_req = 1'b1;
        run_random(80);
        while (hold_cnt < HOLD_CYC) @(posedge aclk);
        hold_req = 1'b0;
        wait_drained();
        stall_on = 1'b1;

        // random phases under several settings
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) set_all('1, '0, {3{16'h4000}});
            else set_all(rand_adjust(), rand_adjust(), rand_adjust());
            run_random(40);
            // sender pauses until the pipe is empty
            while (pix_pending.size() > 0 || s_valid) @(posedge aclk);
            sender_pause = 1'b1;
            while (pix_expected.size() > 0) @(posedge aclk);
            sender_pause = 1'b0;
            run_random(30);
            wait_drained();
        end

        // small offsets, no idling
        stall_on = 1'b0;
        set_all({16'h0100, 16'hFF00, 16'h0080}, {16'hFF80, 16'h0200, 16'h0000},
                {16'h0000, 16'h0000, 16'h0300});
        run_random(60);
        wait_drained();

        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ----- rgb_color_balance_keep_lightness_unit.f -----
+incdir+design
design/cbkl_pkg.sv
design/cbkl_bal.sv
design/cbkl_div.sv
design/cbkl_obuf.sv
design/rgb_color_balance_keep_lightness_unit.sv
design/cbkl_chk.sv
test/testbench.sv
